>>> hdl/rss_pkg.sv
// Shared types, constants and the sine table builder for the ray segment range scanner.
// Depends on nothing; every other file of the block but rss_ram imports it.
`default_nettype none

package rss_pkg;

   localparam int COORD_W = 16;
   localparam int ANG_W   = 16;
   localparam int RANGE_W = 15;
   localparam int IDX_W   = 9;
   localparam int MODE_W  = 2;
   localparam int STAT_W  = 2;
   localparam int CSR_W   = 16;
   localparam int SEG_W   = 4 * COORD_W;
   localparam int DIV_W   = 37;   // magnitude of crossing numerator and denominator

   localparam int DEF_MAX_SEGMENTS = 16;
   localparam int DEF_SCAN_RAYS    = 320;
   localparam int DEF_TRIG_BITS    = 10;

   localparam logic [ANG_W-1:0]   RST_START_ANGLE = 16'd43873;
   localparam logic [ANG_W-1:0]   RST_STEP_ANGLE  = 16'd33;
   localparam logic [RANGE_W-1:0] RST_MAX_RANGE   = 15'd2048;

   localparam longint POLY_C1 = 64'sd421657428;
   localparam longint POLY_C3 = 64'sd173399667;
   localparam longint POLY_C5 = 64'sd21392326;
   localparam longint POLY_C7 = 64'sd1256749;
   localparam longint POLY_C9 = 64'sd43068;
   localparam longint SINE_ONE = 64'sd16384;

   typedef enum logic [MODE_W-1:0] {
      MODE_CLEAR = 2'd0,
      MODE_ADD   = 2'd1,
      MODE_CAST  = 2'd2,
      MODE_NONE  = 2'd3
   } rss_mode_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_RANGE = 2'd2
   } rss_status_type;

   typedef enum logic [1:0] {
      CSR_START_ANGLE = 2'd0,
      CSR_STEP_ANGLE  = 2'd1,
      CSR_MAX_RANGE   = 2'd2
   } rss_csr_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ANG,
      ST_TRIG,
      ST_VEC,
      ST_RD,
      ST_DIFF,
      ST_MUL,
      ST_CMP,
      ST_DIV,
      ST_RESP
   } rss_state_type;

   typedef enum logic [1:0] {
      DV_IDLE,
      DV_MUL,
      DV_DIV
   } rss_div_phase_type;

   // Quarter-wave sine in Q14 for table entry n of a 2^bits entry circle.
   function automatic logic [RANGE_W-1:0] quarter_sine(input int n, input int bits);
      longint x;
      longint x2;
      longint t;
      x  = longint'(n) <<< (18 - bits);
      x2 = (x * x) >>> 16;
      t  = POLY_C9;
      t  = POLY_C7 - ((t * x2) >>> 16);
      t  = POLY_C5 - ((t * x2) >>> 16);
      t  = POLY_C3 - ((t * x2) >>> 16);
      t  = POLY_C1 - ((t * x2) >>> 16);
      t  = (t * x + (64'sd1 <<< 29)) >>> 30;
      if (t > SINE_ONE) begin
         t = SINE_ONE;
      end
      return RANGE_W'(t);
   endfunction

endpackage

`default_nettype wire

>>> hdl/rss_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
`default_nettype none

module rss_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

>>> hdl/rss_trig.sv
// Sine and cosine lookup from a quarter-wave constant table, registered outputs.
// Depends on rss_pkg for widths and the table builder.
`default_nettype none

module rss_trig import rss_pkg::*; #(
   parameter int TRIG_BITS = DEF_TRIG_BITS
) (
   input  wire logic                    clock,
   input  wire logic [ANG_W-1:0]        angle,
   output logic signed [COORD_W-1:0]    sin_ff,
   output logic signed [COORD_W-1:0]    cos_ff
);

   localparam int QUARTER = 1 << (TRIG_BITS - 2);
   localparam logic [ANG_W-1:0] HALF_LSB = ANG_W'(1 << (15 - TRIG_BITS));

   logic [RANGE_W-1:0]   qtab [QUARTER+1];
   logic [ANG_W-1:0]     rounded;
   logic [TRIG_BITS-1:0] sin_idx;
   logic [TRIG_BITS-1:0] cos_idx;
   logic [TRIG_BITS-2:0] sin_n;
   logic [TRIG_BITS-2:0] cos_n;
   logic signed [COORD_W-1:0] sin_in;
   logic signed [COORD_W-1:0] cos_in;

   for (genvar g = 0; g <= QUARTER; g++) begin : g_tab
      assign qtab[g] = quarter_sine(g, TRIG_BITS);
   end

   // The angle is rounded half up to the table resolution, then wrapped.
   assign rounded = angle + HALF_LSB;
   assign sin_idx = rounded[ANG_W-1 -: TRIG_BITS];
   assign cos_idx = sin_idx + TRIG_BITS'(QUARTER);

   always_comb begin
      sin_n = sin_idx[TRIG_BITS-2]
            ? (TRIG_BITS-1)'(QUARTER) - {1'b0, sin_idx[TRIG_BITS-3:0]}
            : {1'b0, sin_idx[TRIG_BITS-3:0]};
      cos_n = cos_idx[TRIG_BITS-2]
            ? (TRIG_BITS-1)'(QUARTER) - {1'b0, cos_idx[TRIG_BITS-3:0]}
            : {1'b0, cos_idx[TRIG_BITS-3:0]};
      sin_in = sin_idx[TRIG_BITS-1] ? -signed'({1'b0, qtab[sin_n]})
                                    :  signed'({1'b0, qtab[sin_n]});
      cos_in = cos_idx[TRIG_BITS-1] ? -signed'({1'b0, qtab[cos_n]})
                                    :  signed'({1'b0, qtab[cos_n]});
   end

   always_ff @(posedge clock) begin
      sin_ff <= sin_in;
      cos_ff <= cos_in;
   end

endmodule

`default_nettype wire

>>> hdl/rss_div.sv
// Shift-add multiplier followed by a restoring divider for the crossing range.
// Depends on rss_pkg. Computes round-half-up(num * rng / den) for num < den.
`default_nettype none

module rss_div import rss_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [DIV_W-1:0]   num,
   input  wire logic [DIV_W-1:0]   den,
   input  wire logic [RANGE_W-1:0] rng,
   output logic                    done_ff,
   output logic [RANGE_W-1:0]      quot_ff
);

   localparam int PW = DIV_W + RANGE_W;   // width of num * rng
   localparam int XW = PW + 2;            // width of 2 * num * rng + den
   localparam int RW = DIV_W + 2;         // partial remainder width
   localparam int CNT_W = $clog2(RANGE_W);

   rss_div_phase_type     phase_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic [PW-1:0]         acc_ff;
   logic [PW-1:0]         acc_in;
   logic [DIV_W-1:0]      num_ff;
   logic [DIV_W-1:0]      den_ff;
   logic [RANGE_W-1:0]    rng_ff;
   logic [RW-1:0]         rem_ff;
   logic [RANGE_W-1:0]    xlo_ff;
   logic [XW-1:0]         x_full;
   logic [RW-1:0]         trial;
   logic [RW-1:0]         divisor;
   logic                  fits;

   always_comb begin
      acc_in  = {acc_ff[PW-2:0], 1'b0} + (rng_ff[cnt_ff] ? PW'(num_ff) : '0);
      x_full  = {1'b0, acc_in, 1'b0} + XW'(den_ff);
      trial   = {rem_ff[RW-2:0], xlo_ff[RANGE_W-1]};
      divisor = {1'b0, den_ff, 1'b0};
      fits    = trial >= divisor;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= DV_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (phase_ff)
            DV_IDLE: begin
               if (start) begin
                  phase_ff <= DV_MUL;
               end
            end
            DV_MUL: begin
               if (cnt_ff == '0) begin
                  phase_ff <= DV_DIV;
               end
            end
            DV_DIV: begin
               if (cnt_ff == '0) begin
                  phase_ff <= DV_IDLE;
                  done_ff  <= 1'b1;
               end
            end
            default: phase_ff <= DV_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (phase_ff)
         DV_IDLE: begin
            num_ff <= num;
            den_ff <= den;
            rng_ff <= rng;
            acc_ff <= '0;
            cnt_ff <= CNT_W'(RANGE_W - 1);
         end
         DV_MUL: begin
            acc_ff <= acc_in;
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               // The quotient is below 2^RANGE_W, so the high part is below the divisor.
               rem_ff <= x_full[XW-1:RANGE_W];
               xlo_ff <= x_full[RANGE_W-1:0];
               cnt_ff <= CNT_W'(RANGE_W - 1);
            end
         end
         DV_DIV: begin
            rem_ff  <= fits ? trial - divisor : trial;
            xlo_ff  <= {xlo_ff[RANGE_W-2:0], 1'b0};
            quot_ff <= {quot_ff[RANGE_W-2:0], fits};
            cnt_ff  <= cnt_ff - 1'b1;
         end
         default: cnt_ff <= cnt_ff;
      endcase
   end

endmodule

`default_nettype wire

>>> hdl/ray_segment_range_scanner_top.sv
// Top level of the ray segment range scanner: handshakes, control sequencer,
// side-test datapath. Depends on rss_pkg, rss_ram, rss_trig and rss_div.
`default_nettype none

// The block simulates a 2D range finder over a table of wall segments held in a
// synchronous RAM. A request transfer carries a mode in req_tuser: clear empties
// the table, add stores one segment (status full when the table holds
// MAX_SEGMENTS), and cast traces ray ray_index from the given pose. Clear, add,
// the unused mode and out-of-range ray indexes go from the request transfer
// straight to the response state. A cast first sets up (ray angle, sine and cosine
// lookup, ray vector), then walks the stored segments through the RAM one at a
// time: each segment is read, differenced, multiplied and compared, and a segment
// that the ray crosses then runs a 15-step multiply and a 15-step divide in one
// shared unit before the quotient is picked up; the response state then hands the
// result to the output register. One item is worked on at a time; a finished
// result waits in the output register while the next request is already being
// taken. Configuration writes take effect at the next clock edge, whatever the
// block is doing, so they belong in gaps where no request is in flight.
module ray_segment_range_scanner_top import rss_pkg::*; #(
   parameter int MAX_SEGMENTS    = DEF_MAX_SEGMENTS,
   parameter int SCAN_RAYS       = DEF_SCAN_RAYS,
   parameter int TRIG_TABLE_BITS = DEF_TRIG_BITS
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // Request channel.
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   // tdata, low bit up: seg_x0, seg_y0, seg_x1, seg_y1, pose_x, pose_y,
   // pose_heading, ray_index, 7 zero bits.
   input  wire logic [127:0]       req_tdata,
   // tuser: mode.
   input  wire logic [MODE_W-1:0]  req_tuser,
   // Result channel.
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   // tdata, low bit up: range_q8, hit, status, 6 zero bits.
   output logic [23:0]             rsp_tdata,
   // Configuration writes.
   input  wire logic               csr_we,
   input  wire logic [1:0]         csr_addr,
   input  wire logic [CSR_W-1:0]   csr_wdata
);

   localparam int CW = $clog2(MAX_SEGMENTS + 1);
   localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int PROD_W = 36;
   localparam int CR_W   = 38;

   rss_state_type state_ff;
   rss_state_type state_in;

   // Configuration registers.
   logic [ANG_W-1:0]   start_angle_ff;
   logic [ANG_W-1:0]   step_angle_ff;
   logic [RANGE_W-1:0] max_range_ff;

   logic [CW-1:0]      count_ff;
   logic [CW-1:0]      seg_idx_ff;
   logic               seg_last;

   // Request fields held for the cast.
   logic signed [COORD_W-1:0] pose_x_ff;
   logic signed [COORD_W-1:0] pose_y_ff;
   logic [ANG_W-1:0]          heading_ff;
   logic [IDX_W-1:0]          ray_idx_ff;

   logic [ANG_W-1:0]          angle_ff;
   logic signed [COORD_W-1:0] sin_ff;
   logic signed [COORD_W-1:0] cos_ff;
   logic signed [31:0]        vx_prod;
   logic signed [31:0]        vy_prod;
   logic signed [16:0]        vx_ff;
   logic signed [16:0]        vy_ff;

   logic [SEG_W-1:0]          seg_rdata;
   logic signed [COORD_W-1:0] ax;
   logic signed [COORD_W-1:0] ay;
   logic signed [COORD_W-1:0] bx;
   logic signed [COORD_W-1:0] by;

   // Differences taken against the segment that was just read.
   logic signed [16:0] aox_ff, aoy_ff, box_ff, boy_ff, tx_ff, ty_ff;
   logic signed [18:0] eax_ff, eay_ff;
   logic signed [PROD_W-1:0] p0a_ff, p0b_ff, p1a_ff, p1b_ff, p2a_ff, p2b_ff;
   logic signed [PROD_W-1:0] pna_ff, pnb_ff, pda_ff, pdb_ff;

   logic signed [CR_W-1:0] c0, c1, c2, num_s, den_s, num_n, den_n;
   logic                   straddle;
   logic                   candidate;
   logic [DIV_W-1:0]       div_num;
   logic [DIV_W-1:0]       div_den;
   logic                   div_start;
   logic                   div_done;
   logic [RANGE_W-1:0]     div_quot;

   logic [RANGE_W-1:0]     best_ff;
   logic                   hit_ff;
   rss_status_type         status_ff;

   logic                   rsp_valid_ff;
   logic [23:0]            rsp_data_ff;
   logic                   req_acc;
   logic                   rsp_load;
   logic                   ram_we;
   rss_mode_type           req_mode;
   logic                   table_full;
   logic                   ray_ok;

   assign req_mode   = rss_mode_type'(req_tuser);
   assign req_acc    = req_tvalid && req_tready;
   assign table_full = count_ff >= CW'(MAX_SEGMENTS);
   assign ray_ok     = req_tdata[120:112] < IDX_W'(SCAN_RAYS);
   assign seg_last   = (seg_idx_ff + CW'(1)) >= count_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   rss_ram #(.WIDTH(SEG_W), .DEPTH(MAX_SEGMENTS)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (count_ff[AW-1:0]),
      .wdata (req_tdata[SEG_W-1:0]),
      .raddr (seg_idx_ff[AW-1:0]),
      .rdata (seg_rdata)
   );

   rss_trig #(.TRIG_BITS(TRIG_TABLE_BITS)) u_trig (
      .clock  (clock),
      .angle  (angle_ff),
      .sin_ff (sin_ff),
      .cos_ff (cos_ff)
   );

   rss_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .num     (div_num),
      .den     (div_den),
      .rng     (max_range_ff),
      .done_ff (div_done),
      .quot_ff (div_quot)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               state_in = (req_mode == MODE_CAST && ray_ok) ? ST_ANG : ST_RESP;
            end
         end
         ST_ANG:  state_in = ST_TRIG;
         ST_TRIG: state_in = ST_VEC;
         ST_VEC:  state_in = (count_ff == '0) ? ST_RESP : ST_RD;
         ST_RD:   state_in = ST_DIFF;
         ST_DIFF: state_in = ST_MUL;
         ST_MUL:  state_in = ST_CMP;
         ST_CMP: begin
            if (candidate) begin
               state_in = ST_DIV;
            end else begin
               state_in = seg_last ? ST_RESP : ST_RD;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = seg_last ? ST_RESP : ST_RD;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control strobes.
   always_comb begin
      req_tready = 1'b0;
      ram_we     = 1'b0;
      div_start  = 1'b0;
      rsp_load   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            ram_we     = req_acc && req_mode == MODE_ADD && !table_full;
         end
         ST_CMP:  div_start = candidate;
         ST_RESP: rsp_load  = !rsp_valid_ff || rsp_tready;
         default: req_tready = 1'b0;
      endcase
   end

   // Segment fields and the crossing tests of the current segment.
   always_comb begin
      ax = seg_rdata[15:0];
      ay = seg_rdata[31:16];
      bx = seg_rdata[47:32];
      by = seg_rdata[63:48];
      vx_prod = signed'({1'b0, max_range_ff}) * cos_ff;
      vy_prod = signed'({1'b0, max_range_ff}) * sin_ff;

      c0    = p0a_ff - p0b_ff;
      c1    = p1a_ff - p1b_ff;
      c2    = p2a_ff - p2b_ff;
      num_s = pna_ff - pnb_ff;
      den_s = pda_ff - pdb_ff;
      // The fourth side test is the negated crossing numerator.
      straddle = !((c0 > 0 && c1 > 0) || (c0 < 0 && c1 < 0)) &&
                 !((c2 > 0 && num_s < 0) || (c2 < 0 && num_s > 0));
      den_n = (den_s < 0) ? -den_s : den_s;
      num_n = (den_s < 0) ? -num_s : num_s;
      if (num_n < 0) begin
         num_n = '0;
      end
      // Parallel or degenerate segments never count, nor a crossing at the ray end.
      candidate = straddle && den_s != 0 && num_n < den_n;
      div_num = num_n[DIV_W-1:0];
      div_den = den_n[DIV_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         count_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
         start_angle_ff <= RST_START_ANGLE;
         step_angle_ff  <= RST_STEP_ANGLE;
         max_range_ff   <= RST_MAX_RANGE;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (rss_csr_type'(csr_addr))
               CSR_START_ANGLE: start_angle_ff <= csr_wdata;
               CSR_STEP_ANGLE:  step_angle_ff  <= csr_wdata;
               CSR_MAX_RANGE:   max_range_ff   <= csr_wdata[RANGE_W-1:0];
               default:         max_range_ff   <= max_range_ff;
            endcase
         end
         if (req_acc && req_mode == MODE_CLEAR) begin
            count_ff <= '0;
         end else if (ram_we) begin
            count_ff <= count_ff + CW'(1);
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= {6'b0, status_ff, hit_ff, best_ff};
      end
      if (req_acc) begin
         pose_x_ff  <= req_tdata[79:64];
         pose_y_ff  <= req_tdata[95:80];
         heading_ff <= req_tdata[111:96];
         ray_idx_ff <= req_tdata[120:112];
         best_ff    <= '0;
         hit_ff     <= 1'b0;
         status_ff  <= STAT_OK;
         if (req_mode == MODE_ADD && table_full) begin
            status_ff <= STAT_FULL;
         end else if (req_mode == MODE_CAST && !ray_ok) begin
            status_ff <= STAT_RANGE;
         end
      end
      case (state_ff)
         ST_ANG: begin
            angle_ff <= heading_ff + start_angle_ff + ANG_W'(ray_idx_ff * step_angle_ff);
         end
         ST_VEC: begin
            vx_ff      <= 17'((vx_prod + 32'sd8192) >>> 14);
            vy_ff      <= 17'((vy_prod + 32'sd8192) >>> 14);
            best_ff    <= max_range_ff;
            seg_idx_ff <= '0;
         end
         ST_DIFF: begin
            aox_ff <= 17'(ax) - 17'(pose_x_ff);
            aoy_ff <= 17'(ay) - 17'(pose_y_ff);
            box_ff <= 17'(bx) - 17'(pose_x_ff);
            boy_ff <= 17'(by) - 17'(pose_y_ff);
            tx_ff  <= 17'(bx) - 17'(ax);
            ty_ff  <= 17'(by) - 17'(ay);
            eax_ff <= 19'(pose_x_ff) + 19'(vx_ff) - 19'(ax);
            eay_ff <= 19'(pose_y_ff) + 19'(vy_ff) - 19'(ay);
         end
         ST_MUL: begin
            p0a_ff <= vx_ff * aoy_ff;
            p0b_ff <= vy_ff * aox_ff;
            p1a_ff <= vx_ff * boy_ff;
            p1b_ff <= vy_ff * box_ff;
            p2a_ff <= tx_ff * eay_ff;
            p2b_ff <= ty_ff * eax_ff;
            pna_ff <= aoy_ff * tx_ff;
            pnb_ff <= aox_ff * ty_ff;
            pda_ff <= vy_ff * tx_ff;
            pdb_ff <= vx_ff * ty_ff;
         end
         ST_CMP: begin
            if (!candidate) begin
               seg_idx_ff <= seg_idx_ff + CW'(1);
            end
         end
         ST_DIV: begin
            if (div_done) begin
               hit_ff     <= 1'b1;
               seg_idx_ff <= seg_idx_ff + CW'(1);
               if (div_quot < best_ff) begin
                  best_ff <= div_quot;
               end
            end
         end
         default: angle_ff <= angle_ff;
      endcase
   end

endmodule

`default_nettype wire

>>> hdl/rss_chk.sv
// Port-level checker for the ray segment range scanner, bound to the top level.
// Depends on rss_pkg for the status codes.
`default_nettype none

module rss_chk import rss_pkg::*; (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_tvalid,
   input wire logic               req_tready,
   input wire logic [MODE_W-1:0]  req_tuser,
   input wire logic               rsp_tvalid,
   input wire logic               rsp_tready,
   input wire logic [23:0]        rsp_tdata
);

   // A stalled result stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // A hit is only reported on a successful cast.
   a_hit_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[15] |-> rsp_tdata[17:16] == STAT_OK)
      else $error("hit with error status");

   // Error results carry no range.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[17:16] != STAT_OK |-> rsp_tdata[15:0] == 16'd0)
      else $error("error result with range");

   // A clear request taken while no result is offered answers with a plain ok and nothing else.
   a_clear_ok: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == MODE_CLEAR && !rsp_tvalid
      |=> ##1 rsp_tvalid && rsp_tdata[17:0] == 18'd0)
      else $error("clear result wrong");

endmodule

bind ray_segment_range_scanner_top rss_chk u_rss_chk (.*);

`default_nettype wire

>>> verif/testbench.sv
// Self-checking testbench for the ray segment range scanner top level.
// Depends on rss_pkg and ray_segment_range_scanner_top; needs no files or arguments.
`default_nettype none

module testbench;
   import rss_pkg::*;

   localparam int MAX_SEG   = DEF_MAX_SEGMENTS;
   localparam int RAYS      = DEF_SCAN_RAYS;
   localparam int TBITS     = DEF_TRIG_BITS;
   localparam int WDOG_MAX  = 20000;

   typedef struct packed {
      rss_mode_type      mode;
      logic [15:0]       x0, y0, x1, y1, px, py, heading;
      logic [8:0]        ray;
   } scan_req_type;

   // Laid out as on rsp_tdata: status on top, range in the low bits.
   typedef struct packed {
      rss_status_type    status;
      logic              hit;
      logic [14:0]       range_q8;
   } scan_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [127:0]      req_tdata = '0;
   logic [MODE_W-1:0] req_tuser = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [23:0]       rsp_tdata;
   logic              csr_we = 1'b0;
   logic [1:0]        csr_addr = '0;
   logic [CSR_W-1:0]  csr_wdata = '0;

   ray_segment_range_scanner_top i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   // Model state of the scanner: registers and the wall table.
   logic [15:0] mdl_start = RST_START_ANGLE;
   logic [15:0] mdl_step  = RST_STEP_ANGLE;
   logic [14:0] mdl_range = RST_MAX_RANGE;
   logic [63:0] walls [MAX_SEG];
   int          wall_count = 0;

   scan_req_type pending_reqs [$];
   scan_rsp_type expected_ranges [$];
   int        errors = 0;
   int        sent = 0;
   int        casts = 0;
   int        hits = 0;
   int        send_idle_pct = 0;
   int        recv_stall_pct = 0;
   int        quiet_cycles = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   // Sine table of the model, built independently at start of run.
   longint sine_tab [1 << TBITS];

   function automatic longint quarter_wave(int n);
      longint x, x2, t;
      x  = longint'(n) <<< (18 - TBITS);
      x2 = (x * x) >>> 16;
      t  = 43068;
      t  = 1256749 - ((t * x2) >>> 16);
      t  = 21392326 - ((t * x2) >>> 16);
      t  = 173399667 - ((t * x2) >>> 16);
      t  = 421657428 - ((t * x2) >>> 16);
      t  = (t * x + (longint'(1) <<< 29)) >>> 30;
      return (t > 16384) ? 16384 : t;
   endfunction

   initial begin
      int q, r, quarter;
      quarter = 1 << (TBITS - 2);
      for (int i = 0; i < (1 << TBITS); i++) begin
         q = (i >> (TBITS - 2)) & 3;
         r = i & (quarter - 1);
         sine_tab[i] = quarter_wave((q & 1) ? quarter - r : r);
         if (q & 2) sine_tab[i] = -sine_tab[i];
      end
   end

   function automatic longint round_q14(longint v);
      return (v + 8192) >>> 14;
   endfunction

   function automatic int side_of(longint ax, longint ay, longint bx, longint by,
                                  longint cx, longint cy);
      longint c;
      c = (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
      return (c > 0) ? 1 : ((c < 0) ? -1 : 0);
   endfunction

   // Traces one ray against every stored wall and returns the nearest crossing.
   function automatic scan_rsp_type trace_ray(scan_req_type rq);
      scan_rsp_type res;
      logic [15:0] ang;
      int ti;
      longint sn, cs, rr, vx, vy, ox, oy, ex, ey, best;
      longint ax, ay, bx, by, tx, ty, den, num, d;
      res = '0;
      ang = rq.heading + mdl_start + 16'(rq.ray * mdl_step);
      ti = (int'(ang) + (1 << (15 - TBITS))) >> (16 - TBITS);
      sn = sine_tab[ti & ((1 << TBITS) - 1)];
      cs = sine_tab[(ti + (1 << (TBITS - 2))) & ((1 << TBITS) - 1)];
      rr = mdl_range;
      vx = round_q14(rr * cs);
      vy = round_q14(rr * sn);
      ox = $signed(rq.px);
      oy = $signed(rq.py);
      ex = ox + vx;
      ey = oy + vy;
      best = rr;
      for (int i = 0; i < wall_count; i++) begin
         ax = $signed(walls[i][15:0]);
         ay = $signed(walls[i][31:16]);
         bx = $signed(walls[i][47:32]);
         by = $signed(walls[i][63:48]);
         if (side_of(ox, oy, ex, ey, ax, ay) * side_of(ox, oy, ex, ey, bx, by) <= 0 &&
             side_of(ax, ay, bx, by, ex, ey) * side_of(ax, ay, bx, by, ox, oy) <= 0) begin
            tx = bx - ax;
            ty = by - ay;
            den = vy * tx - vx * ty;
            num = (ay - oy) * tx - (ax - ox) * ty;
            if (den != 0) begin
               if (den < 0) begin
                  den = -den;
                  num = -num;
               end
               if (num < 0) num = 0;
               if (num < den) begin
                  d = (num * rr * 2 + den) / (2 * den);
                  res.hit = 1'b1;
                  if (d < best) best = d;
               end
            end
         end
      end
      res.range_q8 = best[14:0];
      res.status = STAT_OK;
      return res;
   endfunction

   // Applies one request to the model and queues the result it must produce.
   function automatic void predict_scan(scan_req_type rq);
      scan_rsp_type res;
      res = '0;
      case (rq.mode)
         MODE_CLEAR: wall_count = 0;
         MODE_ADD: begin
            if (wall_count >= MAX_SEG) begin
               res.status = STAT_FULL;
            end else begin
               walls[wall_count] = {rq.y1, rq.x1, rq.y0, rq.x0};
               wall_count++;
            end
         end
         MODE_CAST: begin
            if (rq.ray >= RAYS) begin
               res.status = STAT_RANGE;
            end else begin
               res = trace_ray(rq);
               casts++;
               if (res.hit) hits++;
            end
         end
         default: ;
      endcase
      expected_ranges.push_back(res);
   endfunction

   // Driver: presents queued requests, idling at random between transfers.
   always @(posedge clock) begin
      scan_req_type nx;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predict_scan(pending_reqs.pop_front());
            sent++;
         end
         if ((!req_tvalid || req_tready) ) begin
            if (pending_reqs.size() > (req_tvalid && req_tready ? 0 : 0) &&
                pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nx = pending_reqs[0];
               req_tvalid <= 1'b1;
               req_tdata  <= {7'd0, nx.ray, nx.heading, nx.py, nx.px,
                              nx.y1, nx.x1, nx.y0, nx.x0};
               req_tuser  <= nx.mode;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks every result transfer against the oldest expectation.
   always @(posedge clock) begin
      scan_rsp_type got, exp_r;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[17:0];
            if (expected_ranges.size() == 0) begin
               $error("result transfer with nothing expected: %h", rsp_tdata);
               errors++;
            end else begin
               exp_r = expected_ranges.pop_front();
               if (got.range_q8 !== exp_r.range_q8) begin
                  $error("range_q8 expected %0d actual %0d", exp_r.range_q8, got.range_q8);
                  errors++;
               end
               if (got.hit !== exp_r.hit) begin
                  $error("hit expected %0d actual %0d", exp_r.hit, got.hit);
                  errors++;
               end
               if (got.status !== exp_r.status) begin
                  $error("status expected %0d actual %0d", exp_r.status, got.status);
                  errors++;
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Watchdog: ends the run when nothing moves for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset) begin
         quiet_cycles <= 0;
      end else if (pending_reqs.size() != 0 || expected_ranges.size() != 0) begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WDOG_MAX) begin
            $display("timeout with %0d results outstanding", expected_ranges.size());
            $display("testbench: done, errors");
            $finish;
         end
      end
   end

   function automatic scan_req_type make_req(rss_mode_type m);
      scan_req_type rq;
      rq = $bits(scan_req_type)'({$urandom, $urandom, $urandom, $urandom, $urandom});
      rq.mode = m;
      return rq;
   endfunction

   // A wall of modest size near the origin so that rays actually hit it.
   function automatic scan_req_type near_wall();
      scan_req_type rq;
      rq = make_req(MODE_ADD);
      rq.x0 = 16'($signed($urandom_range(6000)) - 3000);
      rq.y0 = 16'($signed($urandom_range(6000)) - 3000);
      rq.x1 = 16'($signed($urandom_range(6000)) - 3000);
      rq.y1 = 16'($signed($urandom_range(6000)) - 3000);
      return rq;
   endfunction

   function automatic scan_req_type near_cast();
      scan_req_type rq;
      rq = make_req(MODE_CAST);
      rq.px = 16'($signed($urandom_range(1000)) - 500);
      rq.py = 16'($signed($urandom_range(1000)) - 500);
      rq.ray = ($urandom_range(19) == 0) ? 9'($urandom_range(511, RAYS))
                                         : 9'($urandom_range(RAYS - 1));
      return rq;
   endfunction

   task automatic wait_drained();
      while (pending_reqs.size() != 0 || expected_ranges.size() != 0 || req_tvalid)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_csr(rss_csr_type idx, logic [15:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      case (idx)
         CSR_START_ANGLE: mdl_start = val;
         CSR_STEP_ANGLE:  mdl_step = val;
         default:         mdl_range = val[14:0];
      endcase
   endtask

   // Random phase: mostly rays cast near the origin, mixed with walls near it and other modes.
   task automatic random_phase(int n_items);
      scan_req_type rq;
      for (int i = 0; i < n_items; i++) begin
         case ($urandom_range(19))
            0:       pending_reqs.push_back(make_req(MODE_CLEAR));
            1:       pending_reqs.push_back(make_req(MODE_NONE));
            2:       pending_reqs.push_back(make_req(MODE_ADD));
            3:       pending_reqs.push_back(make_req(MODE_CAST));
            4, 5, 6: pending_reqs.push_back(near_wall());
            default: pending_reqs.push_back(near_cast());
         endcase
      end
   endtask

   initial begin
      scan_req_type rq;
      logic [15:0] starts [4];
      logic [15:0] steps [4];
      logic [15:0] ranges [4];
      int idle_set [4][2];
      starts = '{16'd0, 16'hFFFF, 16'd43873, 16'd16384};
      steps  = '{16'd0, 16'hFFFF, 16'd33, 16'd205};
      ranges = '{16'd1, 16'h7FFF, 16'd2048, 16'd600};
      idle_set = '{'{0, 0}, '{54, 0}, '{0, 54}, '{12, 12}};

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed part: three walls of a square around the origin, extremes and errors.
      rq = make_req(MODE_ADD);
      rq.x0 = -16'sd512; rq.y0 = -16'sd512; rq.x1 = 16'sd512; rq.y1 = -16'sd512;
      pending_reqs.push_back(rq);
      rq.x0 = 16'sd512; rq.y0 = 16'sd512;
      pending_reqs.push_back(rq);
      rq.x1 = -16'sd512; rq.y1 = 16'sd512;
      pending_reqs.push_back(rq);
      // A wall parallel to the heading direction and a degenerate point wall.
      rq.x0 = 16'sd100; rq.y0 = 16'sd0; rq.x1 = 16'sd300; rq.y1 = 16'sd0;
      pending_reqs.push_back(rq);
      rq.x1 = 16'sd100;
      pending_reqs.push_back(rq);
      // Extreme coordinates.
      rq.x0 = 16'h8000; rq.y0 = 16'h7FFF; rq.x1 = 16'h7FFF; rq.y1 = 16'h8000;
      pending_reqs.push_back(rq);
      for (int r = 0; r < 4; r++) begin
         rq = make_req(MODE_CAST);
         rq.px = '0; rq.py = '0;
         rq.heading = 16'(r * 16384);
         rq.ray = (r == 3) ? 9'd319 : 9'd0;
         pending_reqs.push_back(rq);
      end
      rq.px = 16'h7FFF; rq.py = 16'h8000; rq.heading = 16'hFFFF; rq.ray = 9'd320;
      pending_reqs.push_back(rq);
      rq.ray = 9'h1FF;
      pending_reqs.push_back(rq);
      pending_reqs.push_back(make_req(MODE_NONE));
      // Fill past capacity to reach the table-full status.
      for (int i = 0; i < MAX_SEG - 5; i++) pending_reqs.push_back(near_wall());
      pending_reqs.push_back(near_cast());
      pending_reqs.push_back(make_req(MODE_CLEAR));
      pending_reqs.push_back(near_cast());
      wait_drained();

      // Random phases across register settings and idling patterns.
      for (int p = 0; p < 16; p++) begin
         write_csr(CSR_START_ANGLE, (p < 4) ? starts[p] : 16'($urandom));
         write_csr(CSR_STEP_ANGLE, steps[p % 4]);
         write_csr(CSR_MAX_RANGE, (p < 8) ? ranges[p / 2] : 16'($urandom_range(32767, 1)));
         send_idle_pct  = idle_set[p % 4][0];
         recv_stall_pct = idle_set[p % 4][1];
         pending_reqs.push_back(make_req(MODE_CLEAR));
         random_phase(115);
         wait_drained();
      end

      $display("Sent %0d request transfers; %0d rays cast, %0d of them hit a wall.",
               sent, casts, hits);
      if (errors == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule

`default_nettype wire
